// ===== hdl/fla_pkg.sv =====
// Shared constants and types for the free-list allocator.
`timescale 1ns / 1ps
`default_nettype none
package fla_pkg;
  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } region_t;
endpackage
`default_nettype wire

// ===== hdl/free_list_allocator.sv =====
// First-fit free-list allocator: address-sorted region table with coalescing.
//
// One command per transaction: raise start while busy is low. The block scans
// the region table one entry at a time through a single memory read port,
// reading each entry and then checking it, then may shift entries by one place
// (a read and a write per entry) to close a gap or open a slot. The scan stops
// at the chosen slot and the shift covers only the entries behind it; a
// read-totals command is answered straight from idle. The result appears for
// exactly one cycle with out_valid high and cannot be held off; the free total
// is kept as a running sum, so no table pass is needed for it.
`timescale 1ns / 1ps
`default_nettype none
module free_list_allocator
  import fla_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_command,
  input  wire logic [31:0]      in_addr,
  input  wire logic [31:0]      in_size,
  output logic                  out_valid,
  output logic [31:0]           out_alloc_addr,
  output logic [1:0]            out_status,
  output logic [31:0]           out_free_total,
  output logic [12:0]           out_entry_count,
  output logic [12:0]           out_peak_count,
  output logic [31:0]           out_lost_count,
  output logic [31:0]           out_lost_bytes
);
  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_F_RD, S_F_CHK, S_SD_RD, S_SD_WR, S_SU_RD, S_SU_WR
  } state_t;

  state_t         st_r;
  logic [CNT_W-1:0] idx_r, j_r, cnt_r, peak_r;
  logic [31:0]    addr_r, size_r, total_r, lost_cnt_r, lost_bytes_r, grant_r;
  logic [1:0]     status_r;
  logic           out_valid_r;
  region_t        prev_r;

  logic           we;
  logic [IDX_W-1:0] waddr, raddr;
  region_t        wdata, rdata;

  fla_ram #(.WIDTH($bits(region_t)), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // free-path decision terms
  logic have_prev, have_cur, prev_touch, next_touch, fdec;
  logic [31:0] merge_len;
  logic [CNT_W-1:0] idx_p1, idx_m1, j_m1;

  always_comb begin
    idx_p1     = idx_r + CNT_W'(1);
    idx_m1     = idx_r - CNT_W'(1);
    j_m1       = j_r - CNT_W'(1);
    have_prev  = idx_r != '0;
    have_cur   = st_r == S_F_CHK;
    prev_touch = have_prev && (prev_r.start + prev_r.len == addr_r);
    next_touch = have_cur && (addr_r + size_r == rdata.start);
    merge_len  = prev_r.len + size_r + (next_touch ? rdata.len : 32'd0);
    fdec       = (st_r == S_F_RD && idx_r == cnt_r) ||
                 (st_r == S_F_CHK && rdata.start > addr_r);
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = idx_r[IDX_W-1:0];
    wdata = rdata;
    raddr = idx_r[IDX_W-1:0];
    unique case (st_r)
      S_A_CHK: begin
        if (rdata.len >= size_r && rdata.len != size_r) begin
          we    = 1'b1;
          wdata = '{start: rdata.start + size_r, len: rdata.len - size_r};
        end
      end
      S_F_RD, S_F_CHK: begin
        if (fdec) begin
          if (prev_touch) begin
            we    = 1'b1;
            waddr = idx_m1[IDX_W-1:0];
            wdata = '{start: prev_r.start, len: merge_len};
          end else if (next_touch) begin
            we    = 1'b1;
            wdata = '{start: addr_r, len: rdata.len + size_r};
          end
        end
      end
      S_SD_WR: begin
        we    = 1'b1;
        waddr = idx_m1[IDX_W-1:0];
      end
      S_SU_RD: begin
        raddr = j_m1[IDX_W-1:0];
        if (j_r == idx_r) begin
          we    = 1'b1;
          wdata = '{start: addr_r, len: size_r};
        end
      end
      S_SU_WR: begin
        we    = 1'b1;
        waddr = j_r[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      cnt_r        <= '0;
      peak_r       <= '0;
      total_r      <= '0;
      lost_cnt_r   <= '0;
      lost_bytes_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            addr_r   <= in_addr;
            size_r   <= in_size;
            idx_r    <= '0;
            grant_r  <= '0;
            status_r <= ST_OK;
            if (in_command == CMD_ALLOC) begin
              if (cnt_r == '0) begin
                status_r    <= ST_NOFIT;
                out_valid_r <= 1'b1;
              end else begin
                st_r <= S_A_RD;
              end
            end else if (in_command == CMD_FREE) begin
              st_r <= S_F_RD;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        S_A_RD: st_r <= S_A_CHK;
        S_A_CHK: begin
          if (rdata.len >= size_r) begin
            grant_r <= rdata.start;
            total_r <= total_r - size_r;
            if (rdata.len == size_r) begin
              idx_r <= idx_p1;
              st_r  <= S_SD_RD;
            end else begin
              out_valid_r <= 1'b1;
              st_r        <= S_IDLE;
            end
          end else if (idx_p1 == cnt_r) begin
            status_r    <= ST_NOFIT;
            out_valid_r <= 1'b1;
            st_r        <= S_IDLE;
          end else begin
            idx_r <= idx_p1;
            st_r  <= S_A_RD;
          end
        end
        S_F_RD, S_F_CHK: begin
          if (fdec) begin
            if (prev_touch || next_touch) begin
              total_r <= total_r + size_r;
              if (prev_touch && next_touch) begin
                idx_r <= idx_p1;
                st_r  <= S_SD_RD;
              end else begin
                out_valid_r <= 1'b1;
                st_r        <= S_IDLE;
              end
            end else if (cnt_r < CNT_W'(TABLE_ENTRIES)) begin
              j_r  <= cnt_r;
              st_r <= S_SU_RD;
            end else begin
              lost_cnt_r   <= lost_cnt_r + 32'd1;
              lost_bytes_r <= lost_bytes_r + size_r;
              status_r     <= ST_FULL;
              out_valid_r  <= 1'b1;
              st_r         <= S_IDLE;
            end
          end else if (st_r == S_F_RD) begin
            st_r <= S_F_CHK;
          end else begin
            prev_r <= rdata;
            idx_r  <= idx_p1;
            st_r   <= S_F_RD;
          end
        end
        S_SD_RD: begin
          if (idx_r == cnt_r) begin
            cnt_r       <= cnt_r - CNT_W'(1);
            out_valid_r <= 1'b1;
            st_r        <= S_IDLE;
          end else begin
            st_r <= S_SD_WR;
          end
        end
        S_SD_WR: begin
          idx_r <= idx_p1;
          st_r  <= S_SD_RD;
        end
        S_SU_RD: begin
          if (j_r == idx_r) begin
            cnt_r       <= cnt_r + CNT_W'(1);
            if (peak_r <= cnt_r) peak_r <= cnt_r + CNT_W'(1);
            total_r     <= total_r + size_r;
            out_valid_r <= 1'b1;
            st_r        <= S_IDLE;
          end else begin
            st_r <= S_SU_WR;
          end
        end
        S_SU_WR: begin
          j_r  <= j_m1;
          st_r <= S_SU_RD;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = st_r != S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_alloc_addr  = grant_r;
  assign out_status      = status_r;
  assign out_free_total  = total_r;
  assign out_entry_count = 13'(cnt_r);
  assign out_peak_count  = 13'(peak_r);
  assign out_lost_count  = lost_cnt_r;
  assign out_lost_bytes  = lost_bytes_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_ENTRIES)) else $error("region count overflow");
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= cnt_r) else $error("peak below count");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NOFIT ||
                   out_status == ST_FULL)) else $error("unknown result status");
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");
endmodule
`default_nettype wire

// ===== hdl/fla_ram.sv =====
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fla_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
